// ===== rtl/transform_matrix_composer_top_macros.svh =====
// Assertion macros of the transform matrix composer port checker.
`ifndef TRANSFORM_MATRIX_COMPOSER_TOP_MACROS_SVH
`define TRANSFORM_MATRIX_COMPOSER_TOP_MACROS_SVH
// Consequent must hold in the same cycle as the antecedent.
`define TMC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("transform composer port check failed");
// Consequent must hold in the cycle after the antecedent.
`define TMC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("transform composer port check failed");
`endif

// ===== rtl/tmc_pkg.sv =====
// Types, constants and functions of the transform matrix composer.
`default_nettype none
package tmc_pkg;
	localparam int CORDIC_STEPS = 16;
	localparam int QW = 34;
	localparam int AW = 35;
	localparam int PW = 2 * QW;
	localparam int SW = QW + 16;
	localparam int ANG_SHIFT = 18;
	localparam int SC_LAT = CORDIC_STEPS + 3;
	localparam int ITEM_BEATS = 16;

	typedef logic signed [QW-1:0] q30_t;
	typedef logic signed [31:0] elem_t;
	typedef elem_t [ITEM_BEATS-1:0] matrix_t;

	localparam logic signed [AW-1:0] PI_Q30 = 35'sd3373259426;
	localparam logic signed [AW-1:0] TWO_PI_Q30 = 35'sd6746518852;
	localparam logic signed [AW-1:0] HALF_PI_Q30 = 35'sd1686629713;
	localparam q30_t ONE_Q30 = 34'sd1073741824;
	localparam q30_t GAIN_Q30 = 34'sd652032874;
	localparam elem_t ONE_Q16 = 32'sd65536;
	localparam logic [3:0] LAST_POS = 4'd15;

	typedef struct packed {
		logic signed [15:0] scale_x;
		logic signed [15:0] scale_y;
		logic signed [15:0] angle_x;
		logic signed [15:0] angle_y;
		logic signed [15:0] angle_z;
		logic signed [31:0] shift_x;
		logic signed [31:0] shift_y;
	} in_t;

	typedef struct packed {
		logic signed [31:0] element;
		logic [3:0] position;
		logic last;
	} out_t;

	// Arctangent of 2^-i in Q30.
	function automatic q30_t atan_q30(input int i);
		logic [31:0] v;
		unique case (i)
			0: v = 32'h3243F6A8;
			1: v = 32'h1DAC6705;
			2: v = 32'h0FADBAFC;
			3: v = 32'h07F56EA6;
			4: v = 32'h03FEAB76;
			5: v = 32'h01FFD55B;
			6: v = 32'h00FFFAAA;
			7: v = 32'h007FFF55;
			8: v = 32'h003FFFEA;
			9: v = 32'h001FFFFD;
			10: v = 32'h000FFFFF;
			11: v = 32'h0007FFFF;
			12: v = 32'h0003FFFF;
			13: v = 32'h0001FFFF;
			14: v = 32'h0000FFFF;
			15: v = 32'h00007FFF;
			16: v = 32'h00003FFF;
			17: v = 32'h00001FFF;
			18: v = 32'h00000FFF;
			19: v = 32'h000007FF;
			20: v = 32'h000003FF;
			21: v = 32'h000001FF;
			22: v = 32'h000000FF;
			23: v = 32'h0000007F;
			default: v = 32'h0;
		endcase
		return q30_t'({2'b00, v});
	endfunction

	// Clamp a wide value to the signed 32-bit range.
	function automatic elem_t sat32(input logic signed [SW-1:0] v);
		if (v > SW'(64'sh7FFFFFFF)) begin
			return 32'sh7FFFFFFF;
		end else if (v < -SW'(64'sh80000000)) begin
			return 32'sh80000000;
		end
		return elem_t'(v);
	endfunction
endpackage
`default_nettype wire

// ===== rtl/tmc_sincos.sv =====
// Pipelined CORDIC lane: cosine and sine in Q30 of one Q4.12 angle.
`default_nettype none
module tmc_sincos (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic signed [15:0] angle,
	output logic out_valid,
	output tmc_pkg::q30_t cos_val,
	output tmc_pkg::q30_t sin_val
);
	import tmc_pkg::*;

	logic signed [AW-1:0] ang_ext, ang_wrap;
	logic signed [AW-1:0] a_s1;
	logic zero_s1, vld_s1;
	logic [CORDIC_STEPS:0] vld_s, neg_s, zero_s;
	q30_t x_s [CORDIC_STEPS+1];
	q30_t y_s [CORDIC_STEPS+1];
	q30_t z_s [CORDIC_STEPS+1];

	always_comb begin
		ang_ext = AW'(angle) <<< ANG_SHIFT;
		if (ang_ext > PI_Q30) begin
			ang_wrap = ang_ext - TWO_PI_Q30;
		end else if (ang_ext < -PI_Q30) begin
			ang_wrap = ang_ext + TWO_PI_Q30;
		end else begin
			ang_wrap = ang_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s[0] <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		a_s1 <= ang_wrap;
		zero_s1 <= (angle == 16'sd0);
		zero_s[0] <= zero_s1;
		x_s[0] <= GAIN_Q30;
		y_s[0] <= '0;
		// Fold into the right half plane; the result is negated at the end.
		if (a_s1 > HALF_PI_Q30) begin
			z_s[0] <= QW'(a_s1 - PI_Q30);
			neg_s[0] <= 1'b1;
		end else if (a_s1 < -HALF_PI_Q30) begin
			z_s[0] <= QW'(a_s1 + PI_Q30);
			neg_s[0] <= 1'b1;
		end else begin
			z_s[0] <= QW'(a_s1);
			neg_s[0] <= 1'b0;
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end
		always_ff @(posedge clk) begin
			neg_s[i+1] <= neg_s[i];
			zero_s[i+1] <= zero_s[i];
			if (z_s[i] >= 0) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - atan_q30(i);
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + atan_q30(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= vld_s[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (zero_s[CORDIC_STEPS]) begin
			cos_val <= ONE_Q30;
			sin_val <= '0;
		end else if (neg_s[CORDIC_STEPS]) begin
			cos_val <= -x_s[CORDIC_STEPS];
			sin_val <= -y_s[CORDIC_STEPS];
		end else begin
			cos_val <= x_s[CORDIC_STEPS];
			sin_val <= y_s[CORDIC_STEPS];
		end
	end
endmodule
`default_nettype wire

// ===== rtl/tmc_compose.sv =====
// Six-stage matrix build: rotation products, scaling, rounding and translation.
`default_nettype none
module tmc_compose (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire tmc_pkg::q30_t ca,
	input wire tmc_pkg::q30_t sa,
	input wire tmc_pkg::q30_t cy,
	input wire tmc_pkg::q30_t sy,
	input wire tmc_pkg::q30_t cz,
	input wire tmc_pkg::q30_t sz,
	input wire tmc_pkg::in_t item,
	output logic out_valid,
	output tmc_pkg::matrix_t mat
);
	import tmc_pkg::*;

	localparam logic signed [PW:0] RND30 = (PW+1)'(1) <<< 29;
	localparam logic signed [SW-1:0] RND22 = SW'(1) <<< 21;
	localparam logic signed [SW-1:0] RND14 = SW'(1) <<< 13;

	logic [5:0] vld_q;
	in_t item_s1, item_s2, item_s3, item_s4, item_s5;
	logic signed [PW-1:0] p_s1 [6];
	q30_t ca_s1, sa_s1, sy_s1, cz_s1, sz_s1;
	q30_t a4_s2, a6_s2, a8_s2, a10_s2, e0_s2, e1_s2;
	q30_t ca_s2, sa_s2, sy_s2, cz_s2, sz_s2;
	logic signed [PW-1:0] q_s3 [8];
	q30_t e0_s3, e1_s3, e2_s3, e6_s3, e10_s3;
	q30_t e0_s4, e1_s4, e2_s4, e4_s4, e5_s4, e6_s4, e8_s4, e9_s4, e10_s4;
	logic signed [SW-1:0] r_s5 [6];
	q30_t e8_s5, e9_s5, e10_s5;

	function automatic q30_t rnd30(input logic signed [PW:0] v);
		return QW'((v + RND30) >>> 30);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[4:0], in_valid};
		end
	end
	assign out_valid = vld_q[5];

	always_ff @(posedge clk) begin
		// Stage 1: products of the X and Y rotations and of the Y and Z rotations.
		p_s1[0] <= sa * sy;
		p_s1[1] <= (-sa) * cy;
		p_s1[2] <= (-ca) * sy;
		p_s1[3] <= ca * cy;
		p_s1[4] <= cy * cz;
		p_s1[5] <= (-cy) * sz;
		ca_s1 <= ca;
		sa_s1 <= sa;
		sy_s1 <= sy;
		cz_s1 <= cz;
		sz_s1 <= sz;
		item_s1 <= item;
		// Stage 2: round to Q30.
		a4_s2 <= rnd30((PW+1)'(p_s1[0]));
		a6_s2 <= rnd30((PW+1)'(p_s1[1]));
		a8_s2 <= rnd30((PW+1)'(p_s1[2]));
		a10_s2 <= rnd30((PW+1)'(p_s1[3]));
		e0_s2 <= rnd30((PW+1)'(p_s1[4]));
		e1_s2 <= rnd30((PW+1)'(p_s1[5]));
		ca_s2 <= ca_s1;
		sa_s2 <= sa_s1;
		sy_s2 <= sy_s1;
		cz_s2 <= cz_s1;
		sz_s2 <= sz_s1;
		item_s2 <= item_s1;
		// Stage 3: products with the Z rotation for rows one and two.
		q_s3[0] <= a4_s2 * cz_s2;
		q_s3[1] <= ca_s2 * sz_s2;
		q_s3[2] <= (-a4_s2) * sz_s2;
		q_s3[3] <= ca_s2 * cz_s2;
		q_s3[4] <= a8_s2 * cz_s2;
		q_s3[5] <= sa_s2 * sz_s2;
		q_s3[6] <= (-a8_s2) * sz_s2;
		q_s3[7] <= sa_s2 * cz_s2;
		e0_s3 <= e0_s2;
		e1_s3 <= e1_s2;
		e2_s3 <= sy_s2;
		e6_s3 <= a6_s2;
		e10_s3 <= a10_s2;
		item_s3 <= item_s2;
		// Stage 4: sum pairs and round to Q30.
		e4_s4 <= rnd30((PW+1)'(q_s3[0]) + (PW+1)'(q_s3[1]));
		e5_s4 <= rnd30((PW+1)'(q_s3[2]) + (PW+1)'(q_s3[3]));
		e8_s4 <= rnd30((PW+1)'(q_s3[4]) + (PW+1)'(q_s3[5]));
		e9_s4 <= rnd30((PW+1)'(q_s3[6]) + (PW+1)'(q_s3[7]));
		e0_s4 <= e0_s3;
		e1_s4 <= e1_s3;
		e2_s4 <= e2_s3;
		e6_s4 <= e6_s3;
		e10_s4 <= e10_s3;
		item_s4 <= item_s3;
		// Stage 5: apply the row scales.
		r_s5[0] <= e0_s4 * item_s4.scale_x;
		r_s5[1] <= e1_s4 * item_s4.scale_x;
		r_s5[2] <= e2_s4 * item_s4.scale_x;
		r_s5[3] <= e4_s4 * item_s4.scale_y;
		r_s5[4] <= e5_s4 * item_s4.scale_y;
		r_s5[5] <= e6_s4 * item_s4.scale_y;
		e8_s5 <= e8_s4;
		e9_s5 <= e9_s4;
		e10_s5 <= e10_s4;
		item_s5 <= item_s4;
		// Stage 6: round to Q16.16 and place the translation.
		mat[0] <= sat32((r_s5[0] + RND22) >>> 22);
		mat[1] <= sat32((r_s5[1] + RND22) >>> 22);
		mat[2] <= sat32((r_s5[2] + RND22) >>> 22);
		mat[3] <= '0;
		mat[4] <= sat32((r_s5[3] + RND22) >>> 22);
		mat[5] <= sat32((r_s5[4] + RND22) >>> 22);
		mat[6] <= sat32((r_s5[5] + RND22) >>> 22);
		mat[7] <= '0;
		mat[8] <= sat32((SW'(e8_s5) + RND14) >>> 14);
		mat[9] <= sat32((SW'(e9_s5) + RND14) >>> 14);
		mat[10] <= sat32((SW'(e10_s5) + RND14) >>> 14);
		mat[11] <= '0;
		mat[12] <= item_s5.shift_x;
		mat[13] <= item_s5.shift_y;
		mat[14] <= '0;
		mat[15] <= ONE_Q16;
	end
endmodule
`default_nettype wire

// ===== rtl/tmc_serial.sv =====
// Holds one finished matrix and sends its sixteen elements one per cycle.
`default_nettype none
module tmc_serial (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic load,
	input wire tmc_pkg::matrix_t mat,
	output logic strobe,
	output tmc_pkg::out_t result
);
	import tmc_pkg::*;

	matrix_t mat_q;
	logic [3:0] cnt_q;
	logic act_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			cnt_q <= '0;
		end else if (load) begin
			act_q <= 1'b1;
			cnt_q <= '0;
		end else if (act_q) begin
			act_q <= (cnt_q != LAST_POS);
			cnt_q <= cnt_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			mat_q <= mat;
		end
	end

	always_comb begin
		strobe = act_q;
		result.element = mat_q[cnt_q];
		result.position = cnt_q;
		result.last = (cnt_q == LAST_POS);
	end
endmodule
`default_nettype wire

// ===== rtl/transform_matrix_composer_top.sv =====
// Top level of the transform matrix composer.
//
// One beat on the input side carries scale, three rotation angles and a
// translation. It is taken at a rising edge where start is high and busy is
// low. The block builds diag(sx, sy, 1, 1) * Rx * Ry * Rz with the translation
// added to elements 12 and 13, and sends the sixteen elements in row-major
// order, one result beat per cycle, marked by strobe, with last on element 15.
// The first element appears after two angle set-up stages, one CORDIC stage
// per step, one sign stage, six matrix stages and the load of the output
// buffer. The remaining fifteen elements follow on consecutive cycles.
// The throughput is set by the single result port that moves one element per
// beat; busy stays high after each accepted beat while its counter runs
// down, so the output buffer is refilled exactly as it empties.
// The receiver cannot stall: every result beat is taken in the cycle it shows.
// Reset clears all valid bits, the busy counter and the output strobe at once;
// the block can take an item in the first cycle after reset is released.
`default_nettype none
module transform_matrix_composer_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire tmc_pkg::in_t item,
	output logic strobe,
	output tmc_pkg::out_t result
);
	import tmc_pkg::*;

	logic [3:0] hold_q;
	logic accept;
	logic [2:0] sc_valid;
	q30_t ca, sa, cy, sy, cz, sz;
	in_t item_s [SC_LAT];
	logic mat_valid;
	matrix_t mat;

	assign accept = start && !busy;
	assign busy = (hold_q != 4'd0);

	// Spaces accepted items so that the result port can send all element beats of one before the next.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= '0;
		end else if (accept) begin
			hold_q <= 4'(ITEM_BEATS - 1);
		end else if (hold_q != 4'd0) begin
			hold_q <= hold_q - 4'd1;
		end
	end

	// Scale and translation ride alongside the CORDIC lanes.
	always_ff @(posedge clk) begin
		item_s[0] <= item;
		for (int k = 1; k < SC_LAT; k++) begin
			item_s[k] <= item_s[k-1];
		end
	end

	tmc_sincos u_sc_x (
		.clk(clk), .arst_n(arst_n), .in_valid(accept), .angle(item.angle_x),
		.out_valid(sc_valid[0]), .cos_val(ca), .sin_val(sa)
	);
	tmc_sincos u_sc_y (
		.clk(clk), .arst_n(arst_n), .in_valid(accept), .angle(item.angle_y),
		.out_valid(sc_valid[1]), .cos_val(cy), .sin_val(sy)
	);
	tmc_sincos u_sc_z (
		.clk(clk), .arst_n(arst_n), .in_valid(accept), .angle(item.angle_z),
		.out_valid(sc_valid[2]), .cos_val(cz), .sin_val(sz)
	);

	tmc_compose u_compose (
		.clk(clk), .arst_n(arst_n), .in_valid(&sc_valid),
		.ca(ca), .sa(sa), .cy(cy), .sy(sy), .cz(cz), .sz(sz),
		.item(item_s[SC_LAT-1]), .out_valid(mat_valid), .mat(mat)
	);

	tmc_serial u_serial (
		.clk(clk), .arst_n(arst_n), .load(mat_valid), .mat(mat),
		.strobe(strobe), .result(result)
	);
endmodule
`default_nettype wire

// ===== rtl/tmc_checker.sv =====
// Port checker for the transform matrix composer and its bind.
`default_nettype none
`include "transform_matrix_composer_top_macros.svh"
module tmc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic strobe,
	input wire tmc_pkg::out_t result
);
	import tmc_pkg::*;

	`TMC_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	`TMC_ASSERT_SAME(a_last_pos, strobe, result.last == (result.position == LAST_POS))
	`TMC_ASSERT_NEXT(a_pos_step, strobe && !result.last, strobe && (result.position == $past(result.position) + 4'd1))
	`TMC_ASSERT_SAME(a_first_pos, $rose(strobe), result.position == 4'd0)
endmodule

bind transform_matrix_composer_top tmc_checker u_chk (.*);
`default_nettype wire

// ===== tb/tb_checker.sv =====
// Checker for the transform matrix composer: predicts each matrix and compares result beats.
`timescale 1ns / 1ps
module tb_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire tmc_pkg::in_t item,
	input wire logic strobe,
	input wire tmc_pkg::out_t result,
	output int fail_count,
	output int pending
);
	import tmc_pkg::*;

	localparam int STEPS = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
	localparam longint PI30 = 64'sd3373259426;
	localparam longint TWO_PI30 = 64'sd6746518852;
	localparam longint HALF_PI30 = 64'sd1686629713;
	localparam longint ONE30 = 64'sd1073741824;
	localparam longint GAIN30 = 64'sd652032874;

	out_t expected_beats[$];
	int beats_seen;

	longint arctan_table[24] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
		64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
		64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
		64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
	};

	// Cosine and sine in Q30 of a Q4.12 angle, by a rotation-mode CORDIC.
	task automatic angle_sincos(input logic signed [15:0] ang, output longint c,
			output longint s);
		longint a, x, y, z, nx;
		bit flip;
		flip = 0;
		if (ang == 0) begin
			c = ONE30;
			s = 0;
			return;
		end
		a = longint'(ang) * 262144;
		while (a > PI30) a -= TWO_PI30;
		while (a < -PI30) a += TWO_PI30;
		if (a > HALF_PI30) begin
			a -= PI30;
			flip = 1;
		end else if (a < -HALF_PI30) begin
			a += PI30;
			flip = 1;
		end
		x = GAIN30;
		y = 0;
		z = a;
		for (int i = 0; i < STEPS; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= arctan_table[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += arctan_table[i];
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	// Multiplies the running matrix by a rotation, rounding each sum half up to Q30.
	task automatic rotate_by(inout longint m[16], input longint r[16]);
		longint t[16];
		longint sum;
		for (int row = 0; row < 4; row++)
			for (int col = 0; col < 4; col++) begin
				sum = 0;
				for (int k = 0; k < 4; k++) sum += m[4*row+k] * r[4*k+col];
				t[4*row+col] = (sum + (64'sd1 <<< 29)) >>> 30;
			end
		m = t;
	endtask

	function automatic void load_identity(ref longint m[16]);
		for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? ONE30 : 0;
	endfunction

	// Builds the sixteen expected element beats of one transform.
	task automatic compose_matrix(input in_t d);
		longint m[16], r[16];
		longint c, s, v;
		out_t beat;
		load_identity(m);
		angle_sincos(d.angle_x, c, s);
		load_identity(r);
		r[5] = c; r[6] = -s; r[9] = s; r[10] = c;
		rotate_by(m, r);
		angle_sincos(d.angle_y, c, s);
		load_identity(r);
		r[0] = c; r[2] = s; r[8] = -s; r[10] = c;
		rotate_by(m, r);
		angle_sincos(d.angle_z, c, s);
		load_identity(r);
		r[0] = c; r[1] = -s; r[4] = s; r[5] = c;
		rotate_by(m, r);
		for (int k = 0; k < 16; k++) begin
			if (k < 4) v = (m[k] * longint'(d.scale_x) + (64'sd1 <<< 21)) >>> 22;
			else if (k < 8) v = (m[k] * longint'(d.scale_y) + (64'sd1 <<< 21)) >>> 22;
			else v = (m[k] + (64'sd1 <<< 13)) >>> 14;
			if (k == 12) v += longint'(d.shift_x);
			if (k == 13) v += longint'(d.shift_y);
			if (v > 64'sd2147483647) v = 64'sd2147483647;
			if (v < -64'sd2147483648) v = -64'sd2147483648;
			beat.element = v[31:0];
			beat.position = 4'(k);
			beat.last = (k == 15);
			expected_beats.push_back(beat);
		end
	endtask

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t, result beat %0d: %s", $time, beats_seen, what);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		beats_seen = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		out_t want;
		if (arst_n) begin
			if (strobe) begin
				if (expected_beats.size() == 0) begin
					report_mismatch($sformatf("unexpected element %h", result));
				end else begin
					want = expected_beats.pop_front();
					if (result.element !== want.element)
						report_mismatch($sformatf("position %0d element %h, want %h",
							want.position, result.element, want.element));
					if (result.position !== want.position)
						report_mismatch($sformatf("position %0d, want %0d",
							result.position, want.position));
					if (result.last !== want.last)
						report_mismatch($sformatf("last %b, want %b at position %0d",
							result.last, want.last, want.position));
				end
				beats_seen++;
			end
			if (start && !busy) compose_matrix(item);
			pending = expected_beats.size();
		end
	end
endmodule

// ===== tb/tb_top.sv =====
// Top of the transform matrix composer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
	import tmc_pkg::*;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_t item;
	logic strobe;
	out_t result;
	int fail_count;
	int pending;
	int cycle_count;
	int items_sent;

	// The sender's idle odds per phase, in cycles out of a hundred.
	int idle_pct;

	localparam int DRAIN_CYCLES = CORDIC_STEPS + 40;
	localparam int CYCLE_LIMIT = 200000;

	transform_matrix_composer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.strobe(strobe),
		.result(result)
	);

	tb_checker checker_inst (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.strobe(strobe),
		.result(result),
		.fail_count(fail_count),
		.pending(pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Watchdog: a run that hangs is a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Test completed with failures");
			$finish;
		end
	end

	// Pick an angle: zero, near the wrap points of +-pi and +-pi/2, or anything.
	function automatic logic signed [15:0] pick_angle();
		case ($urandom_range(0, 5))
			0: return 16'sd0;
			1: return 16'(12868 + $urandom_range(0, 8) - 4);
			2: return 16'(-12868 + $urandom_range(0, 8) - 4);
			3: return 16'(6434 + $urandom_range(0, 8) - 4);
			4: return 16'(-6434 + $urandom_range(0, 8) - 4);
			default: return 16'($urandom);
		endcase
	endfunction

	// Scale is mostly modest so that saturation stays the exception.
	function automatic logic signed [15:0] pick_scale();
		case ($urandom_range(0, 3))
			0: return 16'($urandom);
			1: return 16'sd256;
			default: return 16'($urandom_range(0, 2048) - 1024);
		endcase
	endfunction

	function automatic in_t random_item();
		in_t d;
		d.scale_x = pick_scale();
		d.scale_y = pick_scale();
		d.angle_x = pick_angle();
		d.angle_y = pick_angle();
		d.angle_z = pick_angle();
		d.shift_x = ($urandom_range(0, 3) == 0) ? 32'($urandom) : 32'($urandom_range(0, 2**20) - 2**19);
		d.shift_y = ($urandom_range(0, 3) == 0) ? 32'($urandom) : 32'($urandom_range(0, 2**20) - 2**19);
		return d;
	endfunction

	// Offers one beat at a falling edge and holds it until the block takes it.
	// Random idle cycles go in front of the beat; start stays high between
	// back-to-back beats so no beat is dropped and raised in the same step.
	task automatic send_beat(input in_t d);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		item <= d;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		items_sent++;
		@(negedge clk);
	endtask

	// Drops start and waits until every predicted result beat has come out.
	task automatic wait_drained();
		start <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	in_t beat_data;

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cycle_count = 0;
		items_sent = 0;
		idle_pct = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed beats: identity, field extremes, each angle at zero and at
		// the wrap points, and translations that drive elements 12 and 13
		// to both ends of the signed 32-bit range.
		beat_data = '{16'sd256, 16'sd256, 16'sd0, 16'sd0, 16'sd0, 32'sd0, 32'sd0};
		send_beat(beat_data);
		beat_data = '{16'sh7FFF, 16'sh8000, 16'sd0, 16'sd0, 16'sd0, 32'sh7FFFFFFF, 32'sh80000000};
		send_beat(beat_data);
		beat_data = '{16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
			32'sh80000000, 32'sh7FFFFFFF};
		send_beat(beat_data);
		beat_data = '{16'sd256, 16'sd256, 16'sd6434, 16'sd0, 16'sd0, 32'sd65536, -32'sd65536};
		send_beat(beat_data);
		beat_data = '{16'sd256, 16'sd256, 16'sd0, 16'sd6434, 16'sd0, 32'sd0, 32'sd0};
		send_beat(beat_data);
		beat_data = '{16'sd256, 16'sd256, 16'sd0, 16'sd0, 16'sd6434, 32'sd0, 32'sd0};
		send_beat(beat_data);
		beat_data = '{16'sd256, 16'sd256, 16'sd12868, -16'sd12868, 16'sd12867, 32'sd0, 32'sd0};
		send_beat(beat_data);
		beat_data = '{16'sd256, 16'sd256, 16'sd12869, -16'sd12869, -16'sd6435, 32'sd0, 32'sd0};
		send_beat(beat_data);
		beat_data = '{16'sd512, -16'sd256, -16'sd1, 16'sd1, 16'sd25736, 32'sd1, -32'sd1};
		send_beat(beat_data);
		beat_data = '{16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555,
			32'h55555555, 32'hAAAAAAAA};
		send_beat(beat_data);
		beat_data = '{16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA,
			32'hAAAAAAAA, 32'h55555555};
		send_beat(beat_data);
		beat_data = '{16'sd0, 16'sd0, 16'sd100, 16'sd200, 16'sd300, 32'h7FFF0000, 32'h80010000};
		send_beat(beat_data);

		// The sender holds off until the block has emptied completely.
		wait_drained();

		// Random beats in three phases of sender idling.
		idle_pct = 16;
		repeat (33) send_beat(random_item());
		idle_pct = 77;
		repeat (33) send_beat(random_item());
		wait_drained();
		idle_pct = 0;
		repeat (34) send_beat(random_item());

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Sent %0d transforms: identity, field extremes, angle wrap points,", items_sent);
		$display("saturating translations and random beats under three idle mixes.");
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
